FILE: hw/rtl/tlce_pkg.sv
// Package for the text layout / clip engine.
// Holds command codes, character codes, item kinds, FSM states and field widths.
// No dependencies.
package tlce_pkg;

  localparam int unsigned CharCodesDefault = 256;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned GlyphW  = 8;
  localparam int unsigned TabW    = 10;
  localparam int unsigned AdvW    = 10;
  localparam int unsigned AdvFullW = 11;   // a tab at negative x may move up to 2*tab-1
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW = 4;

  typedef enum logic [1:0] {
    CMD_SET_CURSOR = 2'd0,
    CMD_SET_WIDTH  = 2'd1,
    CMD_CHAR       = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_RIGHT  = 3'd2,
    REG_CLIP_BOTTOM = 3'd3,
    REG_TAB_STOP    = 3'd4,
    REG_LINE_HEIGHT = 3'd5,
    REG_ASCENT      = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_t;

  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  typedef enum logic [1:0] {
    KIND_GLYPH   = 2'd0,
    KIND_TAB     = 2'd1,
    KIND_NEWLINE = 2'd2,
    KIND_RETURN  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOKUP = 2'd1,
    S_DIV    = 2'd2,
    S_DONE   = 2'd3
  } state_t;

  localparam logic [TabW-1:0]   TAB_STOP_RST    = 10'd8;
  localparam logic [7:0]        LINE_HEIGHT_RST = 8'd16;
  localparam logic [7:0]        ASCENT_RST      = 8'd12;

endpackage

FILE: hw/rtl/text_layout_clip_engine_unit.sv
// Text layout and clip engine, top level.
// Depends on tlce_pkg. Contains the glyph width memory, the tab remainder
// divider, the layout state and the result register.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request: set cursor, write a
//   glyph width entry, or lay out one character. Only character requests give
//   a result on the output channel (out_valid/out_ready); the others are
//   absorbed in the cycle they are accepted.
//   Configuration (cfg_we/cfg_index/cfg_wdata) is to be written while idle;
//   the block itself does not enforce this. A glyph goes through accept, width
//   memory read and clip test, and commit; a newline or carriage return through
//   accept and commit; a tab through accept, the bit-serial remainder unit
//   (one quotient bit per cycle) and commit. Other requests end at acceptance.
//   The result sits in an output register; the block takes the next request
//   while it waits. If the receiver stalls, a finished character holds in
//   the commit state until the output register frees.
//   Reset (synchronous, rst_n low) clears the cursor, line widths, string
//   flag and all glyph width valid bits at once: unwritten entries read as
//   zero width. No clearing pass is needed.
module text_layout_clip_engine_unit
  import tlce_pkg::*;
#(
  parameter int unsigned CHAR_CODES = CharCodesDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [CfgIdxW-1:0]          cfg_index,
  input  logic [CfgDataW-1:0]         cfg_wdata,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  logic [7:0]                  in_char_code,
  input  logic [GlyphW-1:0]           in_width_value,
  input  logic signed [CoordW-1:0]    in_new_x,
  input  logic signed [CoordW-1:0]    in_new_y,
  input  logic                        in_end_of_text,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [CoordW-1:0]    out_pos_x,
  output logic signed [CoordW-1:0]    out_pos_y,
  output logic [AdvW-1:0]             out_advance,
  output logic                        out_is_glyph,
  output logic                        out_fully_visible,
  output logic [CoordW-1:0]           out_string_width,
  output logic                        out_last
);

  localparam int unsigned IdxW = (CHAR_CODES > 1) ? $clog2(CHAR_CODES) : 1;

  // configuration registers
  logic [CoordW-1:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic [TabW-1:0]   tab_stop_r;
  logic [7:0]        line_height_r, ascent_r;

  // layout state
  logic [CoordW-1:0] cursor_x_r, cursor_y_r, line_start_x_r, line_width_r, widest_r;
  logic              in_string_r;

  // current item
  kind_t             kind_r;
  logic              eot_r;
  logic [AdvFullW-1:0] adv_r;
  logic              vis_r;

  // glyph width memory
  logic [GlyphW-1:0]     width_mem [CHAR_CODES];
  logic [CHAR_CODES-1:0] wvalid_r;
  logic [GlyphW-1:0]     rd_data_r;
  logic                  rd_hit_r;

  // remainder unit
  logic [CoordW-1:0] div_q_r;
  logic [TabW-1:0]   div_rem_r;
  logic [DivCntW-1:0] div_cnt_r;
  logic              div_neg_r;

  // output register
  logic              out_valid_r;
  logic [CoordW-1:0] out_pos_x_r, out_pos_y_r, out_string_width_r;
  logic [AdvW-1:0]   out_advance_r;
  logic              out_is_glyph_r, out_fully_visible_r, out_last_r;

  state_t state_r, state_nxt;

  logic              accept;
  logic              out_free;
  logic              commit;
  logic              code_in_range;
  logic [IdxW-1:0]   code_idx;
  kind_t             in_kind;
  logic [TabW-1:0]   tab_eff;
  logic signed [CoordW:0] tab_next;
  logic [CoordW-1:0] tab_mag;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign code_in_range = ({1'b0, in_char_code} < 9'(CHAR_CODES));
  assign code_idx = in_char_code[IdxW-1:0];
  assign tab_eff  = (tab_stop_r == '0) ? TabW'(1) : tab_stop_r;
  assign tab_next = $signed({cursor_x_r[CoordW-1], cursor_x_r})
                  + $signed({7'b0, tab_eff});
  assign tab_mag  = tab_next[CoordW] ? CoordW'(-tab_next) : tab_next[CoordW-1:0];

  always_comb begin
    priority if (in_char_code == CHAR_TAB) in_kind = KIND_TAB;
    else if (in_char_code == CHAR_LF)      in_kind = KIND_NEWLINE;
    else if (in_char_code == CHAR_CR)      in_kind = KIND_RETURN;
    else                                   in_kind = KIND_GLYPH;
  end

  // ---------------- FSM ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (cmd_t'(in_command) == CMD_CHAR)) begin
          unique case (in_kind)
            KIND_TAB:                  state_nxt = S_DIV;
            KIND_NEWLINE, KIND_RETURN: state_nxt = S_DONE;
            default:                   state_nxt = S_LOOKUP;
          endcase
        end
      end
      S_LOOKUP: state_nxt = S_DONE;
      S_DIV: begin
        if (div_cnt_r == DivCntW'(DivSteps - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_right_r  <= '0;
      clip_bottom_r <= '0;
      tab_stop_r    <= TAB_STOP_RST;
      line_height_r <= LINE_HEIGHT_RST;
      ascent_r      <= ASCENT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CLIP_LEFT:   clip_left_r   <= cfg_wdata;
        REG_CLIP_TOP:    clip_top_r    <= cfg_wdata;
        REG_CLIP_RIGHT:  clip_right_r  <= cfg_wdata;
        REG_CLIP_BOTTOM: clip_bottom_r <= cfg_wdata;
        REG_TAB_STOP:    tab_stop_r    <= cfg_wdata[TabW-1:0];
        REG_LINE_HEIGHT: line_height_r <= cfg_wdata[7:0];
        REG_ASCENT:      ascent_r      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- glyph width memory ----------------
  // Writes and reads are both issued only from idle, at most one request per
  // cycle, so a read always sees the write of the previous request.
  always_ff @(posedge clk) begin
    if (accept && (cmd_t'(in_command) == CMD_SET_WIDTH) && code_in_range) begin
      width_mem[code_idx] <= in_width_value;
    end
    if (accept && (cmd_t'(in_command) == CMD_CHAR)) begin
      rd_data_r <= width_mem[code_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r <= '0;
      rd_hit_r <= 1'b0;
    end else if (accept) begin
      if ((cmd_t'(in_command) == CMD_SET_WIDTH) && code_in_range) begin
        wvalid_r[code_idx] <= 1'b1;
      end
      if (cmd_t'(in_command) == CMD_CHAR) begin
        rd_hit_r <= code_in_range && wvalid_r[code_idx];
      end
    end
  end

  // ---------------- clip test ----------------
  logic [GlyphW-1:0]       glyph_w;
  logic signed [17:0]      x_s, y_s, cl_s, ct_s, cr_s, cb_s;
  logic                    vis_now;

  assign glyph_w = rd_hit_r ? rd_data_r : '0;
  assign x_s  = 18'($signed(cursor_x_r));
  assign y_s  = 18'($signed(cursor_y_r));
  assign cl_s = 18'($signed(clip_left_r));
  assign ct_s = 18'($signed(clip_top_r));
  assign cr_s = 18'($signed(clip_right_r));
  assign cb_s = 18'($signed(clip_bottom_r));

  assign vis_now = (x_s > cl_s)
                && ((x_s + $signed({10'b0, glyph_w})) < cr_s)
                && ((y_s - $signed({10'b0, ascent_r})) > ct_s)
                && ((y_s + $signed({10'b0, line_height_r}) - $signed({10'b0, ascent_r}))
                    < cb_s);

  // ---------------- tab remainder, one bit per cycle ----------------
  logic [TabW:0]     rem_shift;
  logic              rem_ge;
  logic [TabW-1:0]   rem_new;
  logic [AdvFullW-1:0] tab_adv;

  assign rem_shift = {div_rem_r, div_q_r[CoordW-1]};
  assign rem_ge    = rem_shift >= {1'b0, tab_eff};
  assign rem_new   = rem_ge ? TabW'(rem_shift - {1'b0, tab_eff}) : rem_shift[TabW-1:0];
  // truncating remainder: a negative dividend rounds toward zero, so add it back
  assign tab_adv   = div_neg_r ? ({1'b0, tab_eff} + {1'b0, rem_new})
                               : ({1'b0, tab_eff} - {1'b0, rem_new});

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_r    <= in_kind;
          eot_r     <= in_end_of_text;
          adv_r     <= '0;
          vis_r     <= 1'b0;
          div_q_r   <= tab_mag;
          div_neg_r <= tab_next[CoordW];
          div_rem_r <= '0;
          div_cnt_r <= '0;
        end
      end
      S_LOOKUP: begin
        adv_r <= AdvFullW'(glyph_w);
        vis_r <= vis_now;
      end
      S_DIV: begin
        div_q_r   <= {div_q_r[CoordW-2:0], 1'b0};
        div_rem_r <= rem_new;
        div_cnt_r <= div_cnt_r + DivCntW'(1);
        if (div_cnt_r == DivCntW'(DivSteps - 1)) adv_r <= tab_adv;
      end
      default: ;
    endcase
  end

  // ---------------- layout state and commit ----------------
  logic [CoordW:0]   lw_sum;
  logic [CoordW-1:0] lw_new, wide_new, str_w;
  logic              is_break;

  assign is_break = (kind_r == KIND_NEWLINE) || (kind_r == KIND_RETURN);
  assign lw_sum   = {1'b0, line_width_r} + (CoordW + 1)'(adv_r);
  assign lw_new   = is_break ? '0 : (lw_sum[CoordW] ? '1 : lw_sum[CoordW-1:0]);
  assign wide_new = (is_break && (line_width_r > widest_r)) ? line_width_r : widest_r;
  assign str_w    = is_break ? wide_new : ((lw_new > widest_r) ? lw_new : widest_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      line_start_x_r <= '0;
      line_width_r   <= '0;
      widest_r       <= '0;
      in_string_r    <= 1'b0;
    end else if (accept) begin
      unique case (cmd_t'(in_command))
        CMD_SET_CURSOR: begin
          cursor_x_r <= in_new_x;
          cursor_y_r <= in_new_y;
        end
        CMD_CHAR: begin
          if (!in_string_r) begin
            line_start_x_r <= cursor_x_r;
            line_width_r   <= '0;
            widest_r       <= '0;
            in_string_r    <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (commit) begin
      line_width_r <= lw_new;
      widest_r     <= wide_new;
      if (eot_r) in_string_r <= 1'b0;
      unique case (kind_r)
        KIND_NEWLINE: begin
          cursor_x_r <= line_start_x_r;
          cursor_y_r <= cursor_y_r + CoordW'(line_height_r);
        end
        KIND_RETURN: begin
          cursor_x_r <= clip_left_r;
          cursor_y_r <= cursor_y_r + CoordW'(line_height_r);
        end
        default: cursor_x_r <= cursor_x_r + CoordW'(adv_r);
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_pos_x_r         <= cursor_x_r;
      out_pos_y_r         <= cursor_y_r;
      out_advance_r       <= adv_r[AdvFullW-1] ? '1 : adv_r[AdvW-1:0];
      out_is_glyph_r      <= (kind_r == KIND_GLYPH);
      out_fully_visible_r <= (kind_r == KIND_GLYPH) && vis_r;
      out_string_width_r  <= str_w;
      out_last_r          <= eot_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pos_x         = out_pos_x_r;
  assign out_pos_y         = out_pos_y_r;
  assign out_advance       = out_advance_r;
  assign out_is_glyph      = out_is_glyph_r;
  assign out_fully_visible = out_fully_visible_r;
  assign out_string_width  = out_string_width_r;
  assign out_last          = out_last_r;

  // ---------------- assertions ----------------
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside commit");

  a_lookup_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP) |-> ($past(state_r) == S_IDLE) && $past(accept))
    else $error("width lookup without an accepted character");

  a_visible_is_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_fully_visible_r && !out_is_glyph_r))
    else $error("control character flagged visible");

  a_eot_closes_string: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && eot_r) |=> !in_string_r)
    else $error("string still open after last character");

  a_break_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && is_break) |=> (out_advance_r == '0) && !out_is_glyph_r)
    else $error("line break reported an advance");

endmodule

FILE: sim/text_layout_clip_engine_unit_tb.sv
// Testbench for text_layout_clip_engine_unit: directed table, then random strings.
// Predicts each character placement in SV and checks the results in order.
// Depends on tlce_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench
  import tlce_pkg::*;
();

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  code;
    logic [7:0]  wval;
    logic [15:0] nx;
    logic [15:0] ny;
    logic        eot;
  } text_req_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [9:0]  advance;
    logic        glyph;
    logic        visible;
    logic [15:0] str_width;
    logic        last;
  } placement_t;

  typedef struct packed {
    logic [15:0] clip_left;
    logic [15:0] clip_top;
    logic [15:0] clip_right;
    logic [15:0] clip_bottom;
    logic [9:0]  tab_stop;
    logic [7:0]  line_height;
    logic [7:0]  ascent;
  } layout_cfg_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // For ROW_CFG rows, req.code selects an entry of clip_settings.
  typedef struct packed {
    row_kind_t  kind;
    text_req_t  req;
    logic       typed;
    placement_t want;
  } script_row_t;

  localparam placement_t NO_TYPED = '0;

  localparam layout_cfg_t clip_settings [3] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, TAB_STOP_RST, LINE_HEIGHT_RST, ASCENT_RST},
    '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 10'd1023, 8'd255, 8'd255},
    '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 10'd1, 8'd1, 8'd0}
  };

  script_row_t script [24] = '{
    '{ROW_REQ, '{CMD_CHAR, 8'h41, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
      '{16'h0000, 16'h0000, 10'd0, 1'b1, 1'b0, 16'd0, 1'b0}},
    '{ROW_REQ, '{CMD_SET_WIDTH, 8'h41, 8'hFF, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_SET_WIDTH, 8'hFF, 8'h01, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_SET_WIDTH, 8'h00, 8'h80, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_SET_CURSOR, 8'h00, 8'h00, 16'h7FFF, 16'h8000, 1'b0}, 1'b0, NO_TYPED},
    // x wraps past +32767
    '{ROW_REQ, '{CMD_CHAR, 8'h41, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
      '{16'h7FFF, 16'h8000, 10'd255, 1'b1, 1'b0, 16'd255, 1'b0}},
    '{ROW_REQ, '{CMD_CHAR, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_CHAR, CHAR_TAB, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_CHAR, CHAR_LF, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_CHAR, CHAR_CR, 8'h00, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_NONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_SET_CURSOR, 8'h00, 8'h00, 16'h8000, 16'h7FFF, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_CHAR, 8'hFF, 8'h00, 16'h0000, 16'h0000, 1'b1}, 1'b1,
      '{16'h8000, 16'h7FFF, 10'd1, 1'b1, 1'b0, 16'd1, 1'b1}},
    '{ROW_CFG, '{CMD_NONE, 8'd1, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_SET_CURSOR, 8'h00, 8'h00, 16'hF803, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    // negative-x tab moves 2045 px; advance clamps, width does not
    '{ROW_REQ, '{CMD_CHAR, CHAR_TAB, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
      '{16'hF803, 16'h0000, 10'd1023, 1'b0, 1'b0, 16'd2045, 1'b0}},
    '{ROW_REQ, '{CMD_CHAR, 8'h41, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b1,
      '{16'h0000, 16'h0000, 10'd255, 1'b1, 1'b1, 16'd2300, 1'b0}},
    '{ROW_REQ, '{CMD_CHAR, CHAR_CR, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_CHAR, CHAR_LF, 8'h00, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_TYPED},
    '{ROW_CFG, '{CMD_NONE, 8'd2, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_SET_CURSOR, 8'h00, 8'h00, 16'd100, 16'd100, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_CHAR, CHAR_TAB, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_CHAR, 8'h42, 8'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_TYPED},
    '{ROW_REQ, '{CMD_CHAR, CHAR_LF, 8'h00, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_TYPED}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_command;
  logic [7:0] in_char_code;
  logic [GlyphW-1:0] in_width_value;
  logic signed [CoordW-1:0] in_new_x;
  logic signed [CoordW-1:0] in_new_y;
  logic in_end_of_text;
  logic out_valid;
  logic out_ready = 1'b1;
  logic signed [CoordW-1:0] out_pos_x;
  logic signed [CoordW-1:0] out_pos_y;
  logic [AdvW-1:0] out_advance;
  logic out_is_glyph;
  logic out_fully_visible;
  logic [CoordW-1:0] out_string_width;
  logic out_last;

  text_layout_clip_engine_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_char_code     (in_char_code),
    .in_width_value   (in_width_value),
    .in_new_x         (in_new_x),
    .in_new_y         (in_new_y),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_advance      (out_advance),
    .out_is_glyph     (out_is_glyph),
    .out_fully_visible(out_fully_visible),
    .out_string_width (out_string_width),
    .out_last         (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Layout state mirrored from the block
  layout_cfg_t cur_cfg;
  logic [7:0]  char_width [256];
  logic [15:0] pen_x, pen_y, line_origin, run_width, max_width;
  bit          mid_string;

  placement_t placements_due [$];
  placement_t due;
  int mismatches = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input int b);
    int s;
    s = int'(a) + b;
    return (s > 65535) ? 16'hFFFF : 16'(s);
  endfunction

  // Applies one request to the mirrored state; returns 1 if it yields a placement.
  function automatic bit place_request(input text_req_t r, output placement_t p);
    int x, y, t, nxt, mv, w, cl, ct, cr, cb, d1, d2, d3, d4;
    p = '0;
    case (r.cmd)
      CMD_SET_CURSOR: begin
        pen_x = r.nx;
        pen_y = r.ny;
        return 1'b0;
      end
      CMD_SET_WIDTH: begin
        char_width[r.code] = r.wval;
        return 1'b0;
      end
      CMD_CHAR: ;
      default: return 1'b0;
    endcase

    if (!mid_string) begin
      line_origin = pen_x;
      run_width = '0;
      max_width = '0;
      mid_string = 1'b1;
    end
    x = $signed(pen_x);
    y = $signed(pen_y);
    mv = 0;

    if (r.code == CHAR_TAB) begin
      t = (cur_cfg.tab_stop == 0) ? 1 : int'(cur_cfg.tab_stop);
      nxt = x + t;
      nxt = nxt - (nxt % t);  // truncating remainder, as in C
      mv = nxt - x;
      pen_x = 16'(nxt);
      run_width = sat_add16(run_width, mv);
    end else if (r.code == CHAR_LF || r.code == CHAR_CR) begin
      pen_y = pen_y + 16'(cur_cfg.line_height);
      pen_x = (r.code == CHAR_LF) ? line_origin : cur_cfg.clip_left;
      if (run_width > max_width) max_width = run_width;
      run_width = '0;
    end else begin
      w = int'(char_width[r.code]);
      cl = $signed(cur_cfg.clip_left);
      ct = $signed(cur_cfg.clip_top);
      cr = $signed(cur_cfg.clip_right);
      cb = $signed(cur_cfg.clip_bottom);
      d1 = cl - x;
      d2 = w - cr + x;
      d3 = int'(cur_cfg.ascent) - y + ct;
      d4 = int'(cur_cfg.line_height) - int'(cur_cfg.ascent) - cb + y;
      p.glyph = 1'b1;
      p.visible = (d1 < 0) && (d2 < 0) && (d3 < 0) && (d4 < 0);
      mv = w;
      pen_x = pen_x + 16'(w);
      run_width = sat_add16(run_width, w);
    end

    p.pos_x = 16'(x);
    p.pos_y = 16'(y);
    p.advance = (mv > 1023) ? 10'd1023 : 10'(mv);
    p.str_width = (run_width > max_width) ? run_width : max_width;
    p.last = r.eot;
    if (r.eot) mid_string = 1'b0;
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(input text_req_t r, input bit typed, input placement_t want);
    placement_t p;
    if (!calm && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= r.cmd;
    in_char_code   <= r.code;
    in_width_value <= r.wval;
    in_new_x       <= r.nx;
    in_new_y       <= r.ny;
    in_end_of_text <= r.eot;
    do @(posedge clk); while (!in_ready);
    if (place_request(r, p))
      placements_due.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  // Stops requests and waits for every placement, plus the tab divider's latency.
  task automatic drain();
    in_valid <= 1'b0;
    while (placements_due.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_config(input layout_cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= REG_CLIP_LEFT;   cfg_wdata <= c.clip_left;          @(negedge clk);
    cfg_index <= REG_CLIP_TOP;    cfg_wdata <= c.clip_top;           @(negedge clk);
    cfg_index <= REG_CLIP_RIGHT;  cfg_wdata <= c.clip_right;         @(negedge clk);
    cfg_index <= REG_CLIP_BOTTOM; cfg_wdata <= c.clip_bottom;        @(negedge clk);
    cfg_index <= REG_TAB_STOP;    cfg_wdata <= 16'(c.tab_stop);      @(negedge clk);
    cfg_index <= REG_LINE_HEIGHT; cfg_wdata <= 16'(c.line_height);   @(negedge clk);
    cfg_index <= REG_ASCENT;      cfg_wdata <= 16'(c.ascent);        @(negedge clk);
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic layout_cfg_t random_config();
    layout_cfg_t c;
    int s;
    s = $urandom_range(99);
    if (s < 12) begin
      c = clip_settings[$urandom_range(2, 1)];
    end else if (s < 27) begin
      c.clip_left   = 16'($urandom);
      c.clip_top    = 16'($urandom);
      c.clip_right  = 16'($urandom);
      c.clip_bottom = 16'($urandom);
      c.tab_stop    = 10'($urandom_range(1023, 1));
      c.line_height = 8'($urandom_range(255, 1));
      c.ascent      = 8'($urandom_range(255, 0));
    end else begin
      // window around the usual cursor area so glyphs do land inside
      c.clip_left   = 16'($urandom_range(150, 0) - 100);
      c.clip_top    = 16'($urandom_range(200, 0) - 200);
      c.clip_right  = 16'($urandom_range(800, 150));
      c.clip_bottom = 16'($urandom_range(450, 80));
      c.tab_stop    = ($urandom_range(3) == 0) ? 10'($urandom_range(1023, 1))
                                               : 10'($urandom_range(16, 1));
      c.line_height = 8'($urandom_range(24, 1));
      c.ascent      = 8'($urandom_range(20, 0));
    end
    return c;
  endfunction

  function automatic logic [7:0] rand_code();
    int s;
    s = $urandom_range(99);
    if (s < 60) return 8'($urandom_range(126, 32));
    if (s < 72) return CHAR_TAB;
    if (s < 82) return CHAR_LF;
    if (s < 88) return CHAR_CR;
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic text_req_t cursor_req();
    text_req_t r;
    r = '0;
    r.cmd = CMD_SET_CURSOR;
    if ($urandom_range(9) < 7) begin
      r.nx = 16'($urandom_range(400, 0) - 150);
      r.ny = 16'($urandom_range(500, 0) - 100);
    end else begin
      r.nx = 16'($urandom);
      r.ny = 16'($urandom);
    end
    return r;
  endfunction

  function automatic text_req_t char_req(input logic [7:0] code, input logic eot);
    text_req_t r;
    r = '0;
    r.cmd = CMD_CHAR;
    r.code = code;
    r.eot = eot;
    return r;
  endfunction

  // Receiver: random stall bursts, none in the calm tail
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < out_stall_pct) begin
      stall_left = $urandom_range(12, 1) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (placements_due.size() == 0) begin
        report_mismatch("result with no request pending", $signed(out_pos_x), 0);
      end else begin
        due = placements_due.pop_front();
        if (out_pos_x !== due.pos_x)
          report_mismatch("pos_x", $signed(out_pos_x), $signed(due.pos_x));
        if (out_pos_y !== due.pos_y)
          report_mismatch("pos_y", $signed(out_pos_y), $signed(due.pos_y));
        if (out_advance !== due.advance)
          report_mismatch("advance", out_advance, due.advance);
        if (out_is_glyph !== due.glyph)
          report_mismatch("is_glyph", out_is_glyph, due.glyph);
        if (out_fully_visible !== due.visible)
          report_mismatch("fully_visible", out_fully_visible, due.visible);
        if (out_string_width !== due.str_width)
          report_mismatch("string_width", out_string_width, due.str_width);
        if (out_last !== due.last)
          report_mismatch("last", out_last, due.last);
      end
    end
  end

  initial begin
    int sent, ph, k, len, sel, cut;
    text_req_t r;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CLIP_LEFT;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_command = CMD_NONE;
    in_char_code = '0;
    in_width_value = '0;
    in_new_x = '0;
    in_new_y = '0;
    in_end_of_text = 1'b0;
    cur_cfg = clip_settings[0];
    foreach (char_width[i]) char_width[i] = '0;
    pen_x = '0; pen_y = '0; line_origin = '0;
    run_width = '0; max_width = '0; mid_string = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_gap_pct = 25;
    out_stall_pct = 25;
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        drain();
        apply_config(clip_settings[script[i].req.code]);
      end else begin
        send(script[i].req, script[i].typed, script[i].want);
      end
    end

    sent = 0;
    for (ph = 0; ph < 8; ph++) begin
      drain();
      apply_config(random_config());
      calm = (ph == 7);
      in_gap_pct = calm ? 0 : $urandom_range(2) * 25;
      out_stall_pct = calm ? 0 : $urandom_range(2) * 25;

      repeat (12) begin
        r = '0;
        r.cmd = CMD_SET_WIDTH;
        r.code = 8'($urandom_range(126, 32));
        r.wval = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20, 1));
        send(r, 1'b0, NO_TYPED);
        sent++;
      end

      // one line long enough to pin the line width at 65535
      if (ph % 3 == 2) begin
        r = '0;
        r.cmd = CMD_SET_WIDTH;
        r.code = 8'h57;
        r.wval = 8'hFF;
        send(r, 1'b0, NO_TYPED);
        for (k = 0; k < 270; k++) send(char_req(8'h57, k == 269), 1'b0, NO_TYPED);
        sent += 271;
      end

      while (sent < (ph + 1) * 240 + 30) begin
        sel = $urandom_range(99);
        if (sel < 80) begin
          if ($urandom_range(9) < 7) begin
            send(cursor_req(), 1'b0, NO_TYPED);
            sent++;
          end
          len = $urandom_range(20, 1);
          for (k = 0; k < len; k++) send(char_req(rand_code(), k == len - 1), 1'b0, NO_TYPED);
          sent += len;
        end else if (sel < 92) begin
          r = text_req_t'(($bits(text_req_t))'({$urandom, $urandom}));
          send(r, 1'b0, NO_TYPED);
          if (r.cmd != CMD_NONE) sent++;
        end else if (sel < 98) begin
          // string broken by a cursor move and left unterminated
          len = $urandom_range(10, 2);
          cut = $urandom_range(len - 1, 1);
          for (k = 0; k < len; k++) begin
            if (k == cut) begin
              send(cursor_req(), 1'b0, NO_TYPED);
              sent++;
            end
            send(char_req(rand_code(), 1'b0), 1'b0, NO_TYPED);
          end
          sent += len;
        end else begin
          drain();
        end
      end
    end

    in_valid <= 1'b0;
    for (k = 0; k < 20000 && placements_due.size() > 0; k++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (placements_due.size() != 0)
      report_mismatch("results never arrived", placements_due.size(), 0);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
